// ===== rtl/flcl_pkg.sv =====
// shared types and constants for the fixed capacity list engine
// depends on nothing; used by every module under rtl
package flcl_pkg;

	localparam int DEPTH      = 64;
	localparam int VALUE_BITS = 32;
	localparam int GROUP      = 8;
	localparam int GRP_W      = $clog2(GROUP);
	localparam int NGRP       = DEPTH / GROUP;
	localparam int NGRP_W     = $clog2(NGRP);
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [CNT_W-1:0]      count_t;

	typedef enum logic [2:0] {
		CMD_APPEND      = 3'd0,
		CMD_INSERT      = 3'd1,
		CMD_REMOVE_AT   = 3'd2,
		CMD_REMOVE_LAST = 3'd3,
		CMD_CLEAR       = 3'd4,
		CMD_FIND        = 3'd5,
		CMD_READ        = 3'd6,
		CMD_WRITE       = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_LOAD   = 2'd1,
		CELL_INSERT = 2'd2,
		CELL_REMOVE = 2'd3
	} cell_op_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		cell_op_t op;
		count_t   target;
		count_t   limit;
		value_t   value;
	} cell_ctrl_t;

endpackage

// ===== rtl/fixed_capacity_list_engine.sv =====
// top level of the fixed capacity list engine: command decode, cell chain, result stage
// depends on flcl_pkg, flcl_cell and flcl_reduce
//
// An ordered list of up to 64 words of 32 bits held in a chain of cells, one
// word per cell, plus a count of used entries. A command transfer happens at a
// rising edge with start high and busy low. Every command returns exactly one
// result: done is high for one cycle once the command has passed v_s1 and v_s2,
// and the result ports are valid in that cycle only; the receiver cannot stall, so
// it must take the result when done is high. busy is high while a command is in
// v_s1 or v_s2, so no new command enters until it leaves them. The pipeline depth
// is set by find and read: the cells update or compare all entries at once, and
// the first-match search and the read select go through a two level registered
// tree over groups of eight cells. Refused commands (list full, index not below
// the count, removing from an empty list) raise error_flag and leave the list alone.
module fixed_capacity_list_engine import flcl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic [5:0]  position,
	input  logic [31:0] item_value,
	output logic        done,
	output logic [6:0]  found_position,
	output logic [31:0] read_value,
	output logic [6:0]  entry_count,
	output logic        error_flag
);

	// control state
	count_t used_count_q;
	logic   v_s1;
	logic   v_s2;
	logic   done_q;

	// pipeline payload
	cmd_t             cmd_s1, cmd_s2;
	logic             err_s1, err_s2;
	logic [IDX_W-1:0] pos_s1, pos_s2;
	value_t           value_s1;

	// result registers
	logic [6:0]  found_q;
	logic [31:0] read_q;
	logic [6:0]  count_q;
	logic        err_q;

	// command decode
	logic       accept;
	cmd_t       cmd_in;
	count_t     pos_ext;
	value_t     value_in;
	logic       acc_err;
	count_t     cnt_next;
	cell_ctrl_t ctrl;

	assign accept   = start && !busy;
	assign cmd_in   = cmd_t'(command);
	assign pos_ext  = count_t'(position);
	assign value_in = VALUE_BITS'(item_value);

	always_comb begin
		acc_err      = 1'b0;
		cnt_next     = used_count_q;
		ctrl.op      = CELL_HOLD;
		ctrl.target  = '0;
		ctrl.limit   = used_count_q;
		ctrl.value   = value_in;
		case (cmd_in)
			CMD_APPEND: begin
				if (used_count_q >= count_t'(DEPTH)) acc_err = 1'b1;
				else begin
					ctrl.op     = CELL_LOAD;
					ctrl.target = used_count_q;
					cnt_next    = used_count_q + 1'b1;
				end
			end
			CMD_INSERT: begin
				if (pos_ext >= used_count_q || used_count_q >= count_t'(DEPTH)) acc_err = 1'b1;
				else begin
					// new word lands just after position, the tail moves up one cell
					ctrl.op     = CELL_INSERT;
					ctrl.target = pos_ext + 1'b1;
					cnt_next    = used_count_q + 1'b1;
				end
			end
			CMD_REMOVE_AT: begin
				if (pos_ext >= used_count_q) acc_err = 1'b1;
				else begin
					ctrl.op     = CELL_REMOVE;
					ctrl.target = pos_ext;
					cnt_next    = used_count_q - 1'b1;
				end
			end
			CMD_REMOVE_LAST: begin
				if (used_count_q == '0) acc_err = 1'b1;
				else cnt_next = used_count_q - 1'b1;
			end
			CMD_CLEAR: cnt_next = '0;
			CMD_FIND:  acc_err = 1'b0;
			CMD_READ: begin
				if (pos_ext >= used_count_q) acc_err = 1'b1;
			end
			CMD_WRITE: begin
				if (pos_ext >= used_count_q) acc_err = 1'b1;
				else begin
					ctrl.op     = CELL_LOAD;
					ctrl.target = pos_ext;
				end
			end
			default: acc_err = 1'b0;
		endcase
		// between transfers the chain only compares against the pending search value
		if (!accept) begin
			ctrl.op    = CELL_HOLD;
			ctrl.value = value_s1;
		end
	end

	// cell chain, each cell sees both neighbors for shifts
	value_t           cell_data [DEPTH];
	logic [DEPTH-1:0] cell_match;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		value_t left_w;
		value_t right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		flcl_cell u_cell (
			.clk   (clk),
			.idx   (count_t'(i)),
			.ctrl  (ctrl),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[i]),
			.match (cell_match[i])
		);
	end

	// group level of the search and read select
	logic [NGRP-1:0]  grp_hit_s2;
	logic [GRP_W-1:0] grp_off_s2  [NGRP];
	value_t           grp_data_s2 [NGRP];

	flcl_reduce u_reduce (
		.clk         (clk),
		.match       (cell_match),
		.data        (cell_data),
		.pos_lo      (pos_s1[GRP_W-1:0]),
		.grp_hit_s2  (grp_hit_s2),
		.grp_off_s2  (grp_off_s2),
		.grp_data_s2 (grp_data_s2)
	);

	// final level: first group with a hit, and the read word of the addressed group
	logic   any_hit;
	count_t hit_idx;
	value_t rd_word;

	always_comb begin
		any_hit = |grp_hit_s2;
		hit_idx = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_hit_s2[g]) hit_idx = count_t'((g << GRP_W) + int'(grp_off_s2[g]));
		end
		rd_word = grp_data_s2[pos_s2[IDX_W-1:GRP_W]];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_count_q <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			if (accept) used_count_q <= cnt_next;
			v_s1   <= accept;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= cmd_in;
			err_s1   <= acc_err;
			pos_s1   <= IDX_W'(position);
			value_s1 <= value_in;
		end
		cmd_s2 <= cmd_s1;
		err_s2 <= err_s1;
		pos_s2 <= pos_s1;
		if (v_s2) begin
			// find cannot change the count, so the count register is the not-found answer
			if (cmd_s2 == CMD_FIND) found_q <= 7'(any_hit ? hit_idx : used_count_q);
			else found_q <= '0;
			if (cmd_s2 == CMD_READ && !err_s2) read_q <= 32'(rd_word);
			else read_q <= '0;
			count_q <= 7'(used_count_q);
			err_q   <= err_s2;
		end
	end

	assign busy           = v_s1 || v_s2;
	assign done           = done_q;
	assign found_position = found_q;
	assign read_value     = read_q;
	assign entry_count    = count_q;
	assign error_flag     = err_q;

	// count never passes capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_count_q <= count_t'(DEPTH))
		else $error("entry count above capacity");

	// a refused command leaves the count alone
	a_err_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		accept && acc_err |=> $stable(used_count_q))
		else $error("refused command changed the count");

	// only one command in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v_s1, v_s2, accept}))
		else $error("overlapping commands");

	// every transfer moves through v_s2 and yields a result strobe
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 v_s2 ##1 done_q)
		else $error("result strobe missing");

endmodule

// ===== rtl/flcl_cell.sv =====
// one storage cell of the list chain: holds one entry, shifts with its neighbors
// depends on flcl_pkg
module flcl_cell import flcl_pkg::*; (
	input  logic       clk,
	input  count_t     idx,
	input  cell_ctrl_t ctrl,
	input  value_t     left,
	input  value_t     right,
	output value_t     data,
	output logic       match
);

	value_t data_q;
	value_t data_d;

	always_comb begin
		data_d = data_q;
		case (ctrl.op)
			CELL_LOAD: begin
				if (idx == ctrl.target) data_d = ctrl.value;
			end
			CELL_INSERT: begin
				if (idx == ctrl.target) data_d = ctrl.value;
				else if (idx > ctrl.target && idx <= ctrl.limit) data_d = left;
			end
			CELL_REMOVE: begin
				// idx stays below DEPTH, so idx + 1 fits the count width
				if (idx >= ctrl.target && count_t'(idx + 1'b1) < ctrl.limit) data_d = right;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data  = data_q;
	// only used entries may match
	assign match = (idx < ctrl.limit) && (data_q == ctrl.value);

endmodule

// ===== rtl/flcl_reduce.sv =====
// first registered level of the find and read reduction, one result per group of cells
// depends on flcl_pkg
module flcl_reduce import flcl_pkg::*; (
	input  logic                   clk,
	input  logic [DEPTH-1:0]       match,
	input  value_t                 data [DEPTH],
	input  logic [GRP_W-1:0]       pos_lo,
	output logic [NGRP-1:0]        grp_hit_s2,
	output logic [GRP_W-1:0]       grp_off_s2 [NGRP],
	output value_t                 grp_data_s2 [NGRP]
);

	logic [NGRP-1:0]  hit_d;
	logic [GRP_W-1:0] off_d  [NGRP];
	value_t           data_d [NGRP];

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			hit_d[g]  = |match[g*GROUP +: GROUP];
			off_d[g]  = '0;
			// lowest set bit of the group wins
			for (int k = GROUP - 1; k >= 0; k--) begin
				if (match[g*GROUP + k]) off_d[g] = GRP_W'(k);
			end
			data_d[g] = data[{NGRP_W'(g), pos_lo}];
		end
	end

	always_ff @(posedge clk) begin
		grp_hit_s2 <= hit_d;
		for (int g = 0; g < NGRP; g++) begin
			grp_off_s2[g]  <= off_d[g];
			grp_data_s2[g] <= data_d[g];
		end
	end

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for fixed_capacity_list_engine: directed and random command traffic
// depends on flcl_pkg and the rtl under rtl; every result is checked against an in-bench list model
module testbench;
	import flcl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;

	// one expected result, fields at the port widths
	typedef struct packed {
		logic [6:0]  found;
		logic [31:0] rd;
		logic [6:0]  count;
		logic        err;
	} list_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  command;
	logic [5:0]  position;
	logic [31:0] item_value;
	logic        done;
	logic [6:0]  found_position;
	logic [31:0] read_value;
	logic [6:0]  entry_count;
	logic        error_flag;

	// in-bench copy of the list contents and its fill level
	value_t       list_words [DEPTH];
	int           list_count;
	list_result_t pending_results [$];

	int error_count;
	int sent_count;
	int checked_count;
	int refused_count;
	int find_hits;
	int peak_count;

	fixed_capacity_list_engine uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.position       (position),
		.item_value     (item_value),
		.done           (done),
		.found_position (found_position),
		.read_value     (read_value),
		.entry_count    (entry_count),
		.error_flag     (error_flag)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// applies one command to the list model and returns what the block must answer
	function automatic list_result_t apply_list_command(cmd_t cmd, logic [5:0] pos,
			logic [31:0] val);
		list_result_t r;
		int p;
		int i;
		r = '0;
		p = int'(pos);
		case (cmd)
			CMD_APPEND: begin
				if (list_count >= DEPTH) begin
					r.err = 1'b1;
				end else begin
					list_words[list_count] = val;
					list_count++;
				end
			end
			CMD_INSERT: begin
				// insert just after pos, the tail moves up one place
				if (p >= list_count || list_count >= DEPTH) begin
					r.err = 1'b1;
				end else begin
					for (i = list_count; i > p + 1; i--)
						list_words[i] = list_words[i-1];
					list_words[p+1] = val;
					list_count++;
				end
			end
			CMD_REMOVE_AT: begin
				// the tail moves down over the removed entry
				if (p >= list_count) begin
					r.err = 1'b1;
				end else begin
					for (i = p + 1; i < list_count; i++)
						list_words[i-1] = list_words[i];
					list_count--;
				end
			end
			CMD_REMOVE_LAST: begin
				if (list_count == 0)
					r.err = 1'b1;
				else
					list_count--;
			end
			CMD_CLEAR: begin
				list_count = 0;
			end
			CMD_FIND: begin
				// first match wins, a miss answers the fill level
				r.found = 7'(list_count);
				for (i = list_count - 1; i >= 0; i--)
					if (list_words[i] == val)
						r.found = 7'(i);
			end
			CMD_READ: begin
				if (p >= list_count)
					r.err = 1'b1;
				else
					r.rd = list_words[p];
			end
			default: begin
				if (p >= list_count)
					r.err = 1'b1;
				else
					list_words[p] = val;
			end
		endcase
		r.count = 7'(list_count);
		return r;
	endfunction

	// drives one command and holds it until the transfer; start is left high so that
	// back-to-back commands never drop it
	task automatic send_cmd(input cmd_t cmd, input logic [5:0] pos, input logic [31:0] val);
		list_result_t r;
		start      <= 1'b1;
		command    <= cmd;
		position   <= pos;
		item_value <= val;
		do @(posedge clk); while (busy);
		r = apply_list_command(cmd, pos, val);
		pending_results.push_back(r);
		sent_count++;
		if (r.err)
			refused_count++;
		if (cmd == CMD_FIND && int'(r.found) < list_count)
			find_hits++;
		if (list_count > peak_count)
			peak_count = list_count;
	endtask

	// random sender gap with start low, lengths vary so gaps land on every busy phase
	task automatic sender_gap(input int idle_pct);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// holds off the sender until every outstanding result has been checked
	task automatic wait_results_drained();
		if (pending_results.size() != 0) begin
			start <= 1'b0;
			while (pending_results.size() != 0)
				@(posedge clk);
		end
	endtask

	// empty list refusals, then every command on a short list, with the field extremes
	task automatic test_directed_edges();
		send_cmd(CMD_CLEAR, 6'd0, 32'h0);
		send_cmd(CMD_REMOVE_LAST, 6'd0, 32'h0);
		send_cmd(CMD_REMOVE_AT, 6'd0, 32'h0);
		send_cmd(CMD_REMOVE_AT, 6'd63, 32'hffff_ffff);
		send_cmd(CMD_INSERT, 6'd0, 32'h1);
		send_cmd(CMD_READ, 6'd0, 32'h0);
		send_cmd(CMD_WRITE, 6'd63, 32'hffff_ffff);
		send_cmd(CMD_FIND, 6'd0, 32'h0);
		send_cmd(CMD_APPEND, 6'd63, 32'h0);
		send_cmd(CMD_APPEND, 6'd0, 32'hffff_ffff);
		send_cmd(CMD_INSERT, 6'd0, 32'h5555_5555);
		send_cmd(CMD_INSERT, 6'd2, 32'haaaa_aaaa);
		send_cmd(CMD_INSERT, 6'd4, 32'h1);
		send_cmd(CMD_READ, 6'd1, 32'h0);
		send_cmd(CMD_READ, 6'd3, 32'h0);
		send_cmd(CMD_WRITE, 6'd2, 32'h1234_5678);
		send_cmd(CMD_READ, 6'd2, 32'h0);
		send_cmd(CMD_FIND, 6'd0, 32'haaaa_aaaa);
		send_cmd(CMD_FIND, 6'd0, 32'hdead_beef);
		// duplicate value, find must report the first copy
		send_cmd(CMD_APPEND, 6'd0, 32'h0);
		send_cmd(CMD_FIND, 6'd63, 32'h0);
		send_cmd(CMD_REMOVE_AT, 6'd0, 32'h0);
		send_cmd(CMD_REMOVE_AT, 6'd3, 32'h0);
		send_cmd(CMD_REMOVE_LAST, 6'd0, 32'h0);
		send_cmd(CMD_CLEAR, 6'd0, 32'h0);
	endtask

	// fills the list to capacity and works at the top index
	task automatic test_full_list();
		send_cmd(CMD_CLEAR, 6'd0, 32'h0);
		while (list_count < DEPTH)
			send_cmd(CMD_APPEND, 6'($urandom_range(0, 63)), $urandom());
		send_cmd(CMD_APPEND, 6'd0, 32'hffff_ffff);
		send_cmd(CMD_INSERT, 6'd10, 32'h0);
		send_cmd(CMD_INSERT, 6'd63, 32'h0);
		send_cmd(CMD_READ, 6'd63, 32'h0);
		send_cmd(CMD_WRITE, 6'd63, 32'hffff_ffff);
		send_cmd(CMD_READ, 6'd63, 32'h0);
		send_cmd(CMD_FIND, 6'd0, list_words[DEPTH-1]);
		send_cmd(CMD_FIND, 6'd0, 32'h7e57_0001);
		send_cmd(CMD_REMOVE_AT, 6'd63, 32'h0);
		send_cmd(CMD_READ, 6'd63, 32'h0);
		send_cmd(CMD_INSERT, 6'd62, 32'h0);
		send_cmd(CMD_REMOVE_AT, 6'd0, 32'h0);
		send_cmd(CMD_REMOVE_LAST, 6'd0, 32'h0);
		send_cmd(CMD_INSERT, 6'd0, 32'h8000_0000);
		send_cmd(CMD_READ, 6'd1, 32'h0);
		send_cmd(CMD_FIND, 6'd0, 32'h7e57_0001);
	endtask

	// weighted command choice, growth outweighs shrinkage so the list reaches full
	function automatic cmd_t pick_command();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 25)      return CMD_APPEND;
		else if (roll < 40) return CMD_INSERT;
		else if (roll < 51) return CMD_REMOVE_AT;
		else if (roll < 58) return CMD_REMOVE_LAST;
		else if (roll < 59) return CMD_CLEAR;
		else if (roll < 74) return CMD_FIND;
		else if (roll < 87) return CMD_READ;
		else                return CMD_WRITE;
	endfunction

	// mostly legal indexes, often values already held, the rest is noise
	task automatic test_random_traffic(input int n_items, input int idle_pct);
		cmd_t        cmd;
		logic [5:0]  pos;
		logic [31:0] val;
		for (int n = 0; n < n_items; n++) begin
			cmd = pick_command();
			if (list_count > 0 && $urandom_range(0, 99) < 85)
				pos = 6'($urandom_range(0, list_count - 1));
			else
				pos = 6'($urandom_range(0, 63));
			if (list_count > 0 && $urandom_range(0, 99) < 35)
				val = list_words[$urandom_range(0, list_count - 1)];
			else if ($urandom_range(0, 99) < 5)
				val = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
			else
				val = $urandom();
			sender_gap(idle_pct);
			// now and then the sender waits for the pipe to empty
			if ($urandom_range(0, 199) == 0)
				wait_results_drained();
			send_cmd(cmd, pos, val);
		end
	endtask

	// result checker: the receiver cannot stall, so each done cycle is one transfer
	always @(posedge clk) begin
		list_result_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no command outstanding");
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				checked_count++;
				if (found_position !== exp_r.found) begin
					$error("found_position mismatch: expected %0d, actual %0d",
						exp_r.found, found_position);
					error_count++;
				end
				if (read_value !== exp_r.rd) begin
					$error("read_value mismatch: expected %08h, actual %08h",
						exp_r.rd, read_value);
					error_count++;
				end
				if (entry_count !== exp_r.count) begin
					$error("entry_count mismatch: expected %0d, actual %0d",
						exp_r.count, entry_count);
					error_count++;
				end
				if (error_flag !== exp_r.err) begin
					$error("error_flag mismatch: expected %0b, actual %0b",
						exp_r.err, error_flag);
					error_count++;
				end
			end
		end
	end

	// watchdog, far above the slowest legal run
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("fixed_capacity_list_engine verification failed");
		$finish;
	end

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		command    = CMD_APPEND;
		position   = '0;
		item_value = '0;
		list_count = 0;
		error_count = 0;
		sent_count = 0;
		checked_count = 0;
		refused_count = 0;
		find_hits = 0;
		peak_count = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed_edges();
		test_full_list();
		wait_results_drained();
		// sender idles lightly, then heavily, then runs flat out
		test_random_traffic(430, 16);
		wait_results_drained();
		test_random_traffic(430, 76);
		wait_results_drained();
		test_random_traffic(430, 0);
		wait_results_drained();
		repeat (4) @(posedge clk);

		$display("%0d commands sent, %0d results checked, %0d refused", sent_count,
			checked_count, refused_count);
		$display("%0d find hits, peak fill %0d of %0d entries", find_hits, peak_count, DEPTH);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("fixed_capacity_list_engine verification clean");
		end else begin
			$display("fixed_capacity_list_engine verification failed");
		end
		$finish;
	end

endmodule
